@@ design/mefb_pkg.sv @@
// ----------------------------------------------------------------------------
// mefb_pkg
// Shared types and constants for the mesh edge frame builder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mefb_pkg;

  // Largest edge count the register holds; larger writes clamp to it
  localparam int unsigned MAX_EDGES = 1048576;

  localparam int COORD_W = 32;
  localparam int VEC_W   = 16;
  localparam int ID_W    = 20;
  localparam int ROW_W   = 21;
  localparam int MAG_W   = 33;
  localparam int A_W     = 31;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int QUO_W   = 15;

  // Per-edge data that rides along with the arithmetic
  typedef struct packed {
    logic [2:0]              neg;
    logic signed [VEC_W-1:0] nx;
    logic signed [VEC_W-1:0] ny;
    logic signed [VEC_W-1:0] nz;
    logic [ID_W-1:0]         id;
    logic                    zero;
  } side_t;

  // Side data plus the scaled magnitudes needed by the divider
  typedef struct packed {
    side_t          side;
    logic [A_W-1:0] ax;
    logic [A_W-1:0] ay;
    logic [A_W-1:0] az;
  } sq_tag_t;

endpackage

`default_nettype wire

@@ design/mefb_isqrt.sv @@
// ----------------------------------------------------------------------------
// mefb_isqrt
// Pipelined integer square root, one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mefb_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [mefb_pkg::SUM_W-1:0]    in_sum,
  input  wire mefb_pkg::sq_tag_t             in_tag,
  output logic                               out_valid,
  output logic [mefb_pkg::ROOT_W-1:0]        out_root,
  output mefb_pkg::sq_tag_t                  out_tag
);
  import mefb_pkg::*;

  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 4;

  logic               valid [1:STEPS];
  logic [REM_W-1:0]   rem   [1:STEPS];
  logic [ROOT_W-1:0]  root  [1:STEPS];
  logic [SUM_W-1:0]   rest  [1:STEPS];
  sq_tag_t            tag   [1:STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      logic              cur_valid;
      logic [REM_W-1:0]  cur_rem;
      logic [ROOT_W-1:0] cur_root;
      logic [SUM_W-1:0]  cur_rest;
      sq_tag_t           cur_tag;
      logic [REM_W-1:0]  work;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
        assign cur_valid = in_valid;
        assign cur_rem   = '0;
        assign cur_root  = '0;
        assign cur_rest  = in_sum;
        assign cur_tag   = in_tag;
      end else begin : g_next
        assign cur_valid = valid[k];
        assign cur_rem   = rem[k];
        assign cur_root  = root[k];
        assign cur_rest  = rest[k];
        assign cur_tag   = tag[k];
      end

      // Bring down two bits and try the next root bit
      assign work  = {cur_rem[REM_W-3:0], cur_rest[SUM_W-1 -: 2]};
      assign trial = {2'b00, cur_root, 2'b01};
      assign ge    = (work >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k+1] <= 1'b0;
        end else begin
          valid[k+1] <= cur_valid;
        end
        rem[k+1]  <= ge ? (work - trial) : work;
        root[k+1] <= {cur_root[ROOT_W-2:0], ge};
        rest[k+1] <= {cur_rest[SUM_W-3:0], 2'b00};
        tag[k+1]  <= cur_tag;
      end
    end
  endgenerate

  assign out_valid = valid[STEPS];
  assign out_root  = root[STEPS];
  assign out_tag   = tag[STEPS];

endmodule

`default_nettype wire

@@ design/mefb_divide.sv @@
// ----------------------------------------------------------------------------
// mefb_divide
// Three-lane pipelined restoring divider: round(a * 2^14 / r), one quotient
// bit per stage, 15 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mefb_divide (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [mefb_pkg::ROOT_W-1:0]   in_root,
  input  wire mefb_pkg::sq_tag_t             in_tag,
  output logic                               out_valid,
  output logic [mefb_pkg::QUO_W-1:0]         out_qx,
  output logic [mefb_pkg::QUO_W-1:0]         out_qy,
  output logic [mefb_pkg::QUO_W-1:0]         out_qz,
  output mefb_pkg::side_t                    out_side
);
  import mefb_pkg::*;

  localparam int STEPS = QUO_W;
  localparam int NUM_W = A_W + STEPS + 1;

  logic              valid [1:STEPS];
  logic [ROOT_W-1:0] rr    [1:STEPS];
  logic [NUM_W-1:0]  rem   [1:STEPS][3];
  logic [QUO_W-1:0]  quo   [1:STEPS][3];
  side_t             side  [1:STEPS];

  logic [NUM_W-1:0]  init_rem [3];
  logic [A_W-1:0]    init_a   [3];

  // Form the rounded numerator a * 2^14 + r / 2
  assign init_a[0] = in_tag.ax;
  assign init_a[1] = in_tag.ay;
  assign init_a[2] = in_tag.az;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      init_rem[i] = {1'b0, init_a[i], {(STEPS-1){1'b0}}} +
                    NUM_W'(in_root >> 1);
    end
  end

  genvar k, l;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      localparam int SH = STEPS - 1 - k;
      logic              cur_valid;
      logic [ROOT_W-1:0] cur_r;
      side_t             cur_side;
      logic [NUM_W-1:0]  dv;

      if (k == 0) begin : g_first
        assign cur_valid = in_valid;
        assign cur_r     = in_root;
        assign cur_side  = in_tag.side;
      end else begin : g_next
        assign cur_valid = valid[k];
        assign cur_r     = rr[k];
        assign cur_side  = side[k];
      end

      assign dv = NUM_W'(cur_r) << SH;

      always_ff @(posedge clk) begin
        if (rst) begin
          valid[k+1] <= 1'b0;
        end else begin
          valid[k+1] <= cur_valid;
        end
        rr[k+1]   <= cur_r;
        side[k+1] <= cur_side;
      end

      for (l = 0; l < 3; l++) begin : g_lane
        logic [NUM_W-1:0] cur_rem;
        logic [QUO_W-1:0] cur_quo;
        logic             ge;

        if (k == 0) begin : g_first
          assign cur_rem = init_rem[l];
          assign cur_quo = '0;
        end else begin : g_next
          assign cur_rem = rem[k][l];
          assign cur_quo = quo[k][l];
        end

        // Subtract the shifted divisor when it fits
        assign ge = (cur_rem >= dv);

        always_ff @(posedge clk) begin
          rem[k+1][l] <= ge ? (cur_rem - dv) : cur_rem;
          quo[k+1][l] <= {cur_quo[QUO_W-2:0], ge};
        end
      end
    end
  endgenerate

  assign out_valid = valid[STEPS];
  assign out_qx    = quo[STEPS][0];
  assign out_qy    = quo[STEPS][1];
  assign out_qz    = quo[STEPS][2];
  assign out_side  = side[STEPS];

endmodule

`default_nettype wire

@@ design/mefb_rotate.sv @@
// ----------------------------------------------------------------------------
// mefb_rotate
// Apply signs, then turn the unit direction a quarter turn about the normal
// as n x v + n (n . v), rounded and saturated; five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mefb_rotate (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [mefb_pkg::QUO_W-1:0]    in_qx,
  input  wire logic [mefb_pkg::QUO_W-1:0]    in_qy,
  input  wire logic [mefb_pkg::QUO_W-1:0]    in_qz,
  input  wire mefb_pkg::side_t               in_side,
  input  wire logic [mefb_pkg::ROW_W-1:0]    edge_count,
  output logic                               done,
  output logic [mefb_pkg::ID_W-1:0]          direction_row,
  output logic signed [mefb_pkg::VEC_W-1:0]  direction_x,
  output logic signed [mefb_pkg::VEC_W-1:0]  direction_y,
  output logic signed [mefb_pkg::VEC_W-1:0]  direction_z,
  output logic [mefb_pkg::ROW_W-1:0]         rotated_row,
  output logic signed [mefb_pkg::VEC_W-1:0]  rotated_x,
  output logic signed [mefb_pkg::VEC_W-1:0]  rotated_y,
  output logic signed [mefb_pkg::VEC_W-1:0]  rotated_z
);
  import mefb_pkg::*;

  localparam int PRD_W = 2 * VEC_W;
  localparam int CRS_W = PRD_W + 1;
  localparam int DOT_W = PRD_W + 2;
  localparam int CSH_W = CRS_W + 14;
  localparam int NP_W  = VEC_W + DOT_W;
  localparam int T_W   = NP_W + 1;

  logic [QUO_W-1:0]        q_in [3];
  logic                    v0;
  logic signed [VEC_W-1:0] vv [4][3];
  logic signed [VEC_W-1:0] nn [4][3];
  logic [ID_W-1:0]         id [4];
  logic                    v1, v2, v3;
  logic signed [PRD_W-1:0] prd [9];
  logic signed [CRS_W-1:0] crs [3];
  logic signed [DOT_W-1:0] dot;
  logic signed [CSH_W-1:0] csh [3];
  logic signed [NP_W-1:0]  np [3];
  logic signed [T_W-1:0]   t [3];
  logic signed [T_W-1:0]   tq [3];
  logic signed [VEC_W-1:0] sat [3];

  assign q_in[0] = in_qx;
  assign q_in[1] = in_qy;
  assign q_in[2] = in_qz;

  // Hold the valid bits of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= in_valid;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // Apply signs; a zero difference gives a zero direction
  // Advance the side data along stages one to three
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (in_side.zero) begin
        vv[0][i] <= '0;
      end else if (in_side.neg[i]) begin
        vv[0][i] <= -$signed({1'b0, q_in[i]});
      end else begin
        vv[0][i] <= $signed({1'b0, q_in[i]});
      end
    end
    nn[0][0] <= in_side.nx;
    nn[0][1] <= in_side.ny;
    nn[0][2] <= in_side.nz;
    id[0]    <= in_side.id;
    for (int s = 1; s < 4; s++) begin
      vv[s] <= vv[s-1];
      nn[s] <= nn[s-1];
      id[s] <= id[s-1];
    end
  end

  // Form the nine component products
  always_ff @(posedge clk) begin
    prd[0] <= nn[0][1] * vv[0][2];
    prd[1] <= nn[0][2] * vv[0][1];
    prd[2] <= nn[0][2] * vv[0][0];
    prd[3] <= nn[0][0] * vv[0][2];
    prd[4] <= nn[0][0] * vv[0][1];
    prd[5] <= nn[0][1] * vv[0][0];
    prd[6] <= nn[0][0] * vv[0][0];
    prd[7] <= nn[0][1] * vv[0][1];
    prd[8] <= nn[0][2] * vv[0][2];
  end

  // Combine into cross and dot products
  always_ff @(posedge clk) begin
    crs[0] <= CRS_W'(prd[0]) - CRS_W'(prd[1]);
    crs[1] <= CRS_W'(prd[2]) - CRS_W'(prd[3]);
    crs[2] <= CRS_W'(prd[4]) - CRS_W'(prd[5]);
    dot    <= DOT_W'(prd[6]) + DOT_W'(prd[7]) + DOT_W'(prd[8]);
  end

  // Scale the cross product and multiply the normal by the dot product
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      csh[i] <= $signed({crs[i], 14'b0});
      np[i]  <= nn[2][i] * dot;
    end
  end

  // Round half up at bit 28 and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]  = T_W'(csh[i]) + T_W'(np[i]) + $signed(T_W'(1) << 27);
      tq[i] = t[i] >>> 28;
      if (tq[i] > $signed(T_W'(32767))) begin
        sat[i] = 16'sh7FFF;
      end else if (tq[i] < -$signed(T_W'(32768))) begin
        sat[i] = -16'sh8000;
      end else begin
        sat[i] = tq[i][VEC_W-1:0];
      end
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    direction_row <= id[3];
    direction_x   <= vv[3][0];
    direction_y   <= vv[3][1];
    direction_z   <= vv[3][2];
    rotated_row   <= ROW_W'(id[3]) + edge_count;
    rotated_x     <= sat[0];
    rotated_y     <= sat[1];
    rotated_z     <= sat[2];
  end

endmodule

`default_nettype wire

@@ design/mesh_edge_frame_builder.sv @@
// ----------------------------------------------------------------------------
// mesh_edge_frame_builder
// Per-edge unit direction and quarter-turn rotated direction for a mesh.
// ----------------------------------------------------------------------------
// Usage:
//   Drive one edge on the input ports with start high. busy is always low,
//   so an edge is taken at every clock edge where start is high; a new edge
//   may follow in every cycle. Edges with skip_edge set give no result.
//   Each result appears for one cycle with done high. Throughput is one
//   edge per cycle, set by the fully pipelined square root (32 stages, one
//   root bit each) and divider (15 stages, one quotient bit each) that
//   follow five front stages. The receiver cannot stall: every result
//   must be taken as it comes. edge_count is written through cfg_wr_en /
//   cfg_wr_data; the user must write it only while the block is idle, which
//   the block itself does not enforce. Values above the maximum edge count
//   clamp to it. Synchronous reset clears all valid bits and sets
//   edge_count to zero; edges in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_edge_frame_builder (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] from_x,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] from_y,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] from_z,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] to_x,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] to_y,
  input  wire logic signed [mefb_pkg::COORD_W-1:0] to_z,
  input  wire logic signed [mefb_pkg::VEC_W-1:0]   normal_x,
  input  wire logic signed [mefb_pkg::VEC_W-1:0]   normal_y,
  input  wire logic signed [mefb_pkg::VEC_W-1:0]   normal_z,
  input  wire logic [mefb_pkg::ID_W-1:0]           edge_id,
  input  wire logic                                skip_edge,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mefb_pkg::ROW_W-1:0]          cfg_wr_data,
  output logic                                done,
  output logic [mefb_pkg::ID_W-1:0]           direction_row,
  output logic signed [mefb_pkg::VEC_W-1:0]   direction_x,
  output logic signed [mefb_pkg::VEC_W-1:0]   direction_y,
  output logic signed [mefb_pkg::VEC_W-1:0]   direction_z,
  output logic [mefb_pkg::ROW_W-1:0]          rotated_row,
  output logic signed [mefb_pkg::VEC_W-1:0]   rotated_x,
  output logic signed [mefb_pkg::VEC_W-1:0]   rotated_y,
  output logic signed [mefb_pkg::VEC_W-1:0]   rotated_z
);
  import mefb_pkg::*;

  localparam int SH_W = 6;

  logic [ROW_W-1:0]         edge_count;
  logic signed [MAG_W-1:0]  diff [3];
  logic [COORD_W-1:0]       fr [3];
  logic [COORD_W-1:0]       tt [3];

  logic                     s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic [MAG_W-1:0]         s1_mag [3];
  logic [MAG_W-1:0]         s2_mag [3];
  side_t                    s1_side, s2_side, s3_side, s4_side;
  logic [MAG_W-1:0]         max_mag;
  logic [SH_W-1:0]          bl;
  logic [SH_W-1:0]          s2_bl;
  logic [A_W-1:0]           s3_a [3];
  logic [A_W-1:0]           s4_a [3];
  logic [2*A_W-1:0]         s4_sq [3];
  logic [SUM_W-1:0]         s5_sum;
  sq_tag_t                  s5_tag;
  logic [SUM_W-1:0]         shifted [3];

  logic                     sq_valid;
  logic [ROOT_W-1:0]        sq_root;
  sq_tag_t                  sq_tag;
  logic                     dv_valid;
  logic [QUO_W-1:0]         dv_qx, dv_qy, dv_qz;
  side_t                    dv_side;

  // Never hold off an edge
  assign busy = 1'b0;

  // Hold the edge count register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (cfg_wr_en) begin
      if (32'(cfg_wr_data) > MAX_EDGES) begin
        edge_count <= ROW_W'(MAX_EDGES);
      end else begin
        edge_count <= cfg_wr_data;
      end
    end
  end

  // Stage 1: exact differences and their magnitudes
  assign fr[0] = from_x;
  assign fr[1] = from_y;
  assign fr[2] = from_z;
  assign tt[0] = to_x;
  assign tt[1] = to_y;
  assign tt[2] = to_z;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({tt[i][COORD_W-1], tt[i]}) -
                $signed({fr[i][COORD_W-1], fr[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !skip_edge;
    end
    for (int i = 0; i < 3; i++) begin
      s1_mag[i]     <= diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
      s1_side.neg[i] <= diff[i][MAG_W-1];
    end
    s1_side.nx   <= normal_x;
    s1_side.ny   <= normal_y;
    s1_side.nz   <= normal_z;
    s1_side.id   <= edge_id;
    s1_side.zero <= 1'b0;
  end

  // Stage 2: largest magnitude and its bit length
  always_comb begin
    max_mag = s1_mag[0];
    if (s1_mag[1] > max_mag) begin
      max_mag = s1_mag[1];
    end
    if (s1_mag[2] > max_mag) begin
      max_mag = s1_mag[2];
    end
    bl = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (max_mag[b]) begin
        bl = SH_W'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_mag       <= s1_mag;
    s2_bl        <= bl;
    s2_side.neg  <= s1_side.neg;
    s2_side.nx   <= s1_side.nx;
    s2_side.ny   <= s1_side.ny;
    s2_side.nz   <= s1_side.nz;
    s2_side.id   <= s1_side.id;
    s2_side.zero <= (max_mag == '0);
  end

  // Stage 3: shift so the largest magnitude sits in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {s2_mag[i][MAG_W-2:0], {A_W{1'b0}}} >> s2_bl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s3_a[i] <= shifted[i][A_W-1:0];
    end
    s3_side <= s2_side;
  end

  // Stage 4: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s4_sq[i] <= s3_a[i] * s3_a[i];
    end
    s4_a    <= s3_a;
    s4_side <= s3_side;
  end

  // Stage 5: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_sum      <= SUM_W'(s4_sq[0]) + SUM_W'(s4_sq[1]) + SUM_W'(s4_sq[2]);
    s5_tag.side <= s4_side;
    s5_tag.ax   <= s4_a[0];
    s5_tag.ay   <= s4_a[1];
    s5_tag.az   <= s4_a[2];
  end

  mefb_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_sum    (s5_sum),
    .in_tag    (s5_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  mefb_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_tag    (sq_tag),
    .out_valid (dv_valid),
    .out_qx    (dv_qx),
    .out_qy    (dv_qy),
    .out_qz    (dv_qz),
    .out_side  (dv_side)
  );

  mefb_rotate u_rotate (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (dv_valid),
    .in_qx         (dv_qx),
    .in_qy         (dv_qy),
    .in_qz         (dv_qz),
    .in_side       (dv_side),
    .edge_count    (edge_count),
    .done          (done),
    .direction_row (direction_row),
    .direction_x   (direction_x),
    .direction_y   (direction_y),
    .direction_z   (direction_z),
    .rotated_row   (rotated_row),
    .rotated_x     (rotated_x),
    .rotated_y     (rotated_y),
    .rotated_z     (rotated_z)
  );

endmodule

`default_nettype wire
